[rtl/dnle_pkg.sv]
// dnle_pkg: shared types and constants for the dns name label encoder
// no dependencies; imported by every module of the block
`default_nettype none

package dnle_pkg;

  localparam int unsigned WIRE_W = 13;

  localparam logic [7:0]        DOT_CHAR       = 8'h2E;
  localparam logic [7:0]        TERM_BYTE      = 8'h00;
  localparam logic [WIRE_W-1:0] MAX_WIRE_RESET = 13'd256;

  typedef logic [WIRE_W-1:0] wire_len_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_LABEL_LONG = 2'd1,
    ST_NO_SPACE   = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } ctrl_state_e;

  // broadcast to every cell: move the chain toward the head by one or two
  typedef struct packed {
    logic by_one;
    logic by_two;
  } cell_shift_t;

endpackage

`default_nettype wire

[rtl/dnle_cell.sv]
// dnle_cell: one byte of the label chain, loaded by index or from its neighbors
// depends on dnle_pkg
`default_nettype none

module dnle_cell
  import dnle_pkg::*;
(
  input  wire logic        clk_i,
  input  wire cell_shift_t shift_i,
  input  wire logic        wr_en_i,
  input  wire logic [7:0]  wr_data_i,
  input  wire logic [7:0]  next_one_i,
  input  wire logic [7:0]  next_two_i,
  output      logic [7:0]  data_o
);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    if (wr_en_i) begin
      data_d = wr_data_i;
    end else if (shift_i.by_one) begin
      data_d = next_one_i;
    end else if (shift_i.by_two) begin
      data_d = next_two_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/dnle_ctrl.sv]
// dnle_ctrl: name sequencer, wire space accounting and result register
// depends on dnle_pkg; drives the shift and write controls of the cell chain
`default_nettype none

module dnle_ctrl
  import dnle_pkg::*;
#(
  parameter int unsigned MAX_LABEL = 63,
  localparam int unsigned CW       = $clog2(MAX_LABEL + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire wire_len_t   cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        is_end_i,
  input  wire logic [7:0]  head_byte_i,
  input  wire logic [7:0]  head_next_i,
  output      cell_shift_t shift_o,
  output      logic        char_wr_o,
  output      logic [CW-1:0] wr_idx_o,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  first_byte_o,
  output      logic [7:0]  second_byte_o,
  output      logic        second_valid_o,
  output      logic        name_done_o,
  output      logic [1:0]  status_o
);

  ctrl_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  wire_len_t     wire_q, wire_d;
  wire_len_t     max_q;
  logic          skip_q, skip_d;
  logic          end_q, end_d;
  logic          out_valid_q;

  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       sec_vld_q, sec_vld_d;
  logic       done_q, done_d;
  status_e    status_q, status_d;
  logic       load;

  logic          out_free;
  logic          in_fire;
  logic [WIRE_W:0] label_need;
  logic          term_ok;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign label_need = {1'b0, wire_q} + (WIRE_W + 1)'(count_q) + (WIRE_W + 1)'(1);
  assign term_ok    = ({1'b0, wire_q} + (WIRE_W + 1)'(1)) <= {1'b0, max_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rem_d     = rem_q;
    wire_d    = wire_q;
    skip_d    = skip_q;
    end_d     = end_q;
    shift_o   = '0;
    char_wr_o = 1'b0;
    load      = 1'b0;
    first_d   = '0;
    second_d  = '0;
    sec_vld_d = 1'b0;
    done_d    = 1'b0;
    status_d  = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (skip_q) begin
            if (is_end_i) begin
              skip_d  = 1'b0;
              count_d = '0;
              wire_d  = '0;
            end
          end else if (!is_end_i && char_byte_i != DOT_CHAR) begin
            if (count_q == CW'(MAX_LABEL)) begin
              load     = 1'b1;
              done_d   = 1'b1;
              status_d = ST_LABEL_LONG;
              skip_d   = 1'b1;
              count_d  = '0;
              wire_d   = '0;
            end else begin
              char_wr_o = 1'b1;
              count_d   = count_q + CW'(1);
            end
          end else if (count_q == '0) begin
            // empty label closes the name early
            load     = 1'b1;
            done_d   = 1'b1;
            first_d  = TERM_BYTE;
            status_d = term_ok ? ST_OK : ST_NO_SPACE;
            skip_d   = !is_end_i;
            count_d  = '0;
            wire_d   = '0;
          end else if (label_need > {1'b0, max_q}) begin
            load     = 1'b1;
            done_d   = 1'b1;
            status_d = ST_NO_SPACE;
            skip_d   = !is_end_i;
            count_d  = '0;
            wire_d   = '0;
          end else begin
            // length byte rides with the first label byte
            load            = 1'b1;
            first_d         = 8'(count_q);
            second_d        = head_byte_i;
            sec_vld_d       = 1'b1;
            shift_o.by_one  = 1'b1;
            rem_d           = count_q - CW'(1);
            count_d         = '0;
            wire_d          = label_need[WIRE_W-1:0];
            end_d           = is_end_i;
            if (count_q == CW'(1) && !is_end_i) begin
              state_d = S_IDLE;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if ({1'b0, rem_q} >= (CW + 1)'(2)) begin
            first_d        = head_byte_i;
            second_d       = head_next_i;
            sec_vld_d      = 1'b1;
            shift_o.by_two = 1'b1;
            rem_d          = rem_q - CW'(2);
            if ({1'b0, rem_q} == (CW + 1)'(2) && !end_q) begin
              state_d = S_IDLE;
            end
          end else if (rem_q == CW'(1)) begin
            first_d = head_byte_i;
            rem_d   = '0;
            if (end_q && term_ok) begin
              second_d  = TERM_BYTE;
              sec_vld_d = 1'b1;
              done_d    = 1'b1;
              wire_d    = '0;
              state_d   = S_IDLE;
            end else if (!end_q) begin
              state_d = S_IDLE;
            end
          end else begin
            // terminator alone, or the space error after the last label
            first_d  = TERM_BYTE;
            done_d   = 1'b1;
            status_d = term_ok ? ST_OK : ST_NO_SPACE;
            wire_d   = '0;
            state_d  = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      wire_q      <= '0;
      skip_q      <= 1'b0;
      end_q       <= 1'b0;
      max_q       <= MAX_WIRE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      wire_q      <= wire_d;
      skip_q      <= skip_d;
      end_q       <= end_d;
      out_valid_q <= load || (out_valid_q && !out_ready_i);
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      first_q   <= first_d;
      second_q  <= second_d;
      sec_vld_q <= sec_vld_d;
      done_q    <= done_d;
      status_q  <= status_d;
    end
  end

  assign wr_idx_o       = count_q;
  assign out_valid_o    = out_valid_q;
  assign first_byte_o   = first_q;
  assign second_byte_o  = second_q;
  assign second_valid_o = sec_vld_q;
  assign name_done_o    = done_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

[rtl/dns_name_label_encoder_core.sv]
// Encodes a dotted domain name, one character per transaction, into DNS wire
// labels: a length byte, the label bytes, and a zero byte at the end of the
// name, packed two wire bytes per result. Label bytes are held in a chain of
// MAX_LABEL byte cells and drained from its head two per cycle while the
// output register is free. A dot or an end item that closes a label holds
// the input until the label and, for an end item, the terminator have moved
// into the output register, one result per step; a result that waits there
// stalls the input further. An empty label ends the name, a label over
// MAX_LABEL bytes or a name over max_wire_length bytes gives one error result
// with name_done set, and the rest of that name is dropped up to its end
// item. Already delivered bytes of a failed name are void.
// depends on dnle_pkg, dnle_cell, dnle_ctrl
`default_nettype none

module dns_name_label_encoder_core
  import dnle_pkg::*;
#(
  parameter int unsigned MAX_LABEL = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        is_end_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  first_byte_o,
  output      logic [7:0]  second_byte_o,
  output      logic        second_valid_o,
  output      logic        name_done_o,
  output      logic [1:0]  status_o
);

  localparam int unsigned CW = $clog2(MAX_LABEL + 1);

  logic [7:0]    cell_data [MAX_LABEL + 2];
  cell_shift_t   shift;
  logic          char_wr;
  logic [CW-1:0] wr_idx;

  assign cell_data[MAX_LABEL]     = '0;
  assign cell_data[MAX_LABEL + 1] = '0;

  for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
    dnle_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .wr_en_i    (char_wr && (wr_idx == CW'(i))),
      .wr_data_i  (char_byte_i),
      .next_one_i (cell_data[i + 1]),
      .next_two_i (cell_data[i + 2]),
      .data_o     (cell_data[i])
    );
  end

  dnle_ctrl #(
    .MAX_LABEL (MAX_LABEL)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .is_end_i       (is_end_i),
    .head_byte_i    (cell_data[0]),
    .head_next_i    (cell_data[1]),
    .shift_o        (shift),
    .char_wr_o      (char_wr),
    .wr_idx_o       (wr_idx),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_byte_o   (first_byte_o),
    .second_byte_o  (second_byte_o),
    .second_valid_o (second_valid_o),
    .name_done_o    (name_done_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

[rtl/dnle_checker.sv]
// dnle_checker: port level checks of the dns name label encoder results
// depends on dnle_pkg; bound to dns_name_label_encoder_core
`default_nettype none

module dnle_checker
  import dnle_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] first_byte_o,
  input wire logic [7:0] second_byte_o,
  input wire logic       second_valid_o,
  input wire logic       name_done_o,
  input wire logic [1:0] status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(first_byte_o)
      && $stable(second_byte_o) && $stable(second_valid_o)
      && $stable(name_done_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> name_done_o && !second_valid_o
      && first_byte_o == 8'h00 && second_byte_o == 8'h00)
    else $error("error result carries wire bytes");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_LABEL_LONG
      || status_o == ST_NO_SPACE)
    else $error("status code out of range");

  a_unused_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !second_valid_o |-> second_byte_o == 8'h00)
    else $error("unused second byte not zero");

  a_terminated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_done_o && status_o == ST_OK |->
      (second_valid_o && second_byte_o == TERM_BYTE)
      || (!second_valid_o && first_byte_o == TERM_BYTE))
    else $error("name finished without terminator");

endmodule

bind dns_name_label_encoder_core dnle_checker u_dnle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .first_byte_o   (first_byte_o),
  .second_byte_o  (second_byte_o),
  .second_valid_o (second_valid_o),
  .name_done_o    (name_done_o),
  .status_o       (status_o)
);

`default_nettype wire

[tb/dnle_checker.sv]
// dnle_scoreboard: watches the config port and both channels of the dns name label encoder,
// predicts the wire results of every accepted character and compares them in order
// depends on dnle_pkg
`timescale 1ns / 1ps

module dnle_scoreboard
  import dnle_pkg::*;
#(
  parameter int unsigned MAX_LABEL = 63
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        is_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [7:0]  first_byte_i,
  input  wire logic [7:0]  second_byte_i,
  input  wire logic        second_valid_i,
  input  wire logic        name_done_i,
  input  wire logic [1:0]  status_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               chars_o,
  output int               live_chars_o,
  output int               beats_o
);

  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] trail;
    logic       trail_vld;
    logic       done;
    status_e    st;
  } wire_beat_t;

  wire_beat_t  beat_q[$];
  wire_beat_t  due_beat;
  logic [7:0]  emit_q[$];
  logic [7:0]  label_buf [MAX_LABEL];
  int unsigned label_len;
  int unsigned name_wire_cnt;
  logic        skip_name;
  wire_len_t   wire_limit;

  function automatic void push_beat(logic [7:0] b0, logic [7:0] b1, logic v1, logic done,
                                    status_e st);
    wire_beat_t b;
    b.lead      = b0;
    b.trail     = b1;
    b.trail_vld = v1;
    b.done      = done;
    b.st        = st;
    beat_q.push_back(b);
  endfunction

  // two wire bytes per result, done flag on the last one
  function automatic void pack_wire_bytes(logic done);
    int unsigned cnt;
    cnt = emit_q.size();
    for (int unsigned i = 0; i < cnt; i += 2) begin
      if (i + 1 < cnt) begin
        push_beat(emit_q[i], emit_q[i+1], 1'b1, (i + 2 >= cnt) ? done : 1'b0, ST_OK);
      end else begin
        push_beat(emit_q[i], 8'h00, 1'b0, done, ST_OK);
      end
    end
  endfunction

  function automatic void close_name(logic last);
    if (!last) skip_name = 1'b1;
    label_len     = 0;
    name_wire_cnt = 0;
  endfunction

  function automatic void encode_char(logic [7:0] ch, logic last);
    int unsigned n;
    if (skip_name) begin
      if (last) begin
        skip_name     = 1'b0;
        label_len     = 0;
        name_wire_cnt = 0;
      end
      return;
    end
    if (!last && ch != DOT_CHAR) begin
      if (label_len >= MAX_LABEL) begin
        push_beat(8'h00, 8'h00, 1'b0, 1'b1, ST_LABEL_LONG);
        close_name(1'b0);
      end else begin
        label_buf[label_len] = ch;
        label_len++;
      end
      return;
    end
    n = label_len;
    if (n == 0) begin
      if (name_wire_cnt + 1 > wire_limit) begin
        push_beat(8'h00, 8'h00, 1'b0, 1'b1, ST_NO_SPACE);
      end else begin
        push_beat(TERM_BYTE, 8'h00, 1'b0, 1'b1, ST_OK);
      end
      close_name(last);
      return;
    end
    if (name_wire_cnt + n + 1 > wire_limit) begin
      push_beat(8'h00, 8'h00, 1'b0, 1'b1, ST_NO_SPACE);
      close_name(last);
      return;
    end
    emit_q.delete();
    emit_q.push_back(8'(n));
    for (int unsigned i = 0; i < n; i++) emit_q.push_back(label_buf[i]);
    name_wire_cnt += n + 1;
    label_len = 0;
    if (!last) begin
      pack_wire_bytes(1'b0);
      return;
    end
    if (name_wire_cnt + 1 > wire_limit) begin
      pack_wire_bytes(1'b0);
      push_beat(8'h00, 8'h00, 1'b0, 1'b1, ST_NO_SPACE);
    end else begin
      emit_q.push_back(TERM_BYTE);
      pack_wire_bytes(1'b1);
    end
    close_name(1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q.delete();
      label_len     = 0;
      name_wire_cnt = 0;
      skip_name     = 1'b0;
      wire_limit    = MAX_WIRE_RESET;
      fail_count_o  = 0;
      pending_o     = 0;
      chars_o       = 0;
      live_chars_o  = 0;
      beats_o       = 0;
    end else begin
      if (cfg_we_i) wire_limit = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        chars_o++;
        if (!skip_name) live_chars_o++;
        encode_char(char_byte_i, is_end_i);
      end
      if (out_valid_i && out_ready_i) begin
        beats_o++;
        if (beat_q.size() == 0) begin
          $error("unexpected result transaction: first_byte %02h second_byte %02h status %0d",
                 first_byte_i, second_byte_i, status_i);
          fail_count_o++;
        end else begin
          due_beat = beat_q.pop_front();
          if (first_byte_i !== due_beat.lead) begin
            $error("first_byte mismatch: expected %02h, actual %02h", due_beat.lead,
                   first_byte_i);
            fail_count_o++;
          end
          if (second_byte_i !== due_beat.trail) begin
            $error("second_byte mismatch: expected %02h, actual %02h", due_beat.trail,
                   second_byte_i);
            fail_count_o++;
          end
          if (second_valid_i !== due_beat.trail_vld) begin
            $error("second_valid mismatch: expected %0b, actual %0b", due_beat.trail_vld,
                   second_valid_i);
            fail_count_o++;
          end
          if (name_done_i !== due_beat.done) begin
            $error("name_done mismatch: expected %0b, actual %0b", due_beat.done,
                   name_done_i);
            fail_count_o++;
          end
          if (status_i !== due_beat.st) begin
            $error("status mismatch: expected %0d, actual %0d", due_beat.st, status_i);
            fail_count_o++;
          end
        end
      end
      pending_o = beat_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// tb_top: clock, reset and stimulus for dns_name_label_encoder_core, plus the verdict
// depends on dnle_pkg, dns_name_label_encoder_core and dnle_scoreboard
`timescale 1ns / 1ps

module tb_top;
  import dnle_pkg::*;

  localparam int unsigned MAX_LABEL = 63;
  localparam int          IDLE_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_byte;
  logic        is_end;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic        second_valid;
  logic        name_done;
  logic [1:0]  status;

  int fail_count;
  int pending;
  int chars_seen;
  int live_chars;
  int beats_seen;
  int idle_run;
  int burst_left;
  int stall_left;
  int ready_duty;
  int base_cnt;
  int unsigned limit_c;
  int unsigned limit_d;

  dns_name_label_encoder_core #(.MAX_LABEL(MAX_LABEL)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .char_byte_i    (char_byte),
    .is_end_i       (is_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .first_byte_o   (first_byte),
    .second_byte_o  (second_byte),
    .second_valid_o (second_valid),
    .name_done_o    (name_done),
    .status_o       (status)
  );

  dnle_scoreboard #(.MAX_LABEL(MAX_LABEL)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .char_byte_i    (char_byte),
    .is_end_i       (is_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .first_byte_i   (first_byte),
    .second_byte_i  (second_byte),
    .second_valid_i (second_valid),
    .name_done_i    (name_done),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .chars_o        (chars_seen),
    .live_chars_o   (live_chars),
    .beats_o        (beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls with a duty cycle that is redrawn at random whenever its run ends
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    ready_duty = 100;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_duty = 100;
          1: ready_duty = 75;
          2: ready_duty = 40;
          default: ready_duty = 10;
        endcase
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      out_ready <= ($urandom_range(1, 100) <= ready_duty);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_valid  <= 1'b1;
    char_byte <= ch;
    is_end    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_label(input int unsigned len);
    logic [7:0] ch;
    for (int unsigned i = 0; i < len; i++) begin
      ch = 8'($urandom_range(0, 255));
      while (ch == DOT_CHAR) ch = 8'($urandom_range(0, 255));
      send_item(ch, 1'b0);
    end
  endtask

  // big_len > 0 gives a single label of that length
  task automatic rand_name(input int unsigned big_len);
    int unsigned labels;
    if (big_len > 0) begin
      send_label(big_len);
    end else begin
      labels = $urandom_range(0, 4);
      for (int unsigned i = 0; i < labels; i++) begin
        if (i > 0) send_item(DOT_CHAR, 1'b0);
        send_label(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
      end
      if ($urandom_range(0, 7) == 0) send_item(DOT_CHAR, 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic set_wire_limit(input logic [12:0] value);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_names(input int target);
    base_cnt = live_chars;
    while (live_chars - base_cnt < target) rand_name(0);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    char_byte  = '0;
    is_end     = 1'b0;
    burst_left = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed names at the reset limit
    send_text("ab");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(DOT_CHAR, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b1);
    send_text(".x");
    send_text("a..");
    send_text("a.");
    send_item(8'hFF, 1'b1);

    // terminator and label overflow of a tight limit
    set_wire_limit(13'd4);
    send_text("abc");
    send_text("abcd.");

    set_wire_limit(13'd4096);
    rand_name(MAX_LABEL + 1);
    run_names(12);

    set_wire_limit(13'd1);
    run_names(4);

    limit_c = $urandom_range(2, 24);
    set_wire_limit(13'(limit_c));
    run_names(8);

    limit_d = $urandom_range(25, 4095);
    set_wire_limit(13'(limit_d));
    run_names(8);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(negedge clk);

    $display("covered %0d input transactions (%0d not skipped), %0d result transactions",
             chars_seen, live_chars, beats_seen);
    $display("wire limits 256, 4, 4096, 1, %0d and %0d; a full %0d byte label overrun",
             limit_c, limit_d, MAX_LABEL);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dnle_pkg.sv
rtl/dnle_cell.sv
rtl/dnle_ctrl.sv
rtl/dns_name_label_encoder_core.sv
rtl/dnle_checker.sv
tb/dnle_checker.sv
tb/tb_top.sv
